[design/ptdt_pkg.sv]
// Package for the periodic task dispatch table: slot record, status, action
// and sequencer state types, plus sizing constants. No dependencies.

package ptdt_pkg;

    localparam int SLOTS_DEF  = 8;
    localparam int RESULT_CAP = 8;

    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_ZERO_PERIOD = 3'd2,
        ST_BAD_KIND    = 3'd3,
        ST_NULL_TASK   = 3'd4,
        ST_NOTHING     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [7:0]  prio;
        logic [15:0] period;
        logic        periodic;
        logic [31:0] next_due;
    } slot_t;

endpackage

[design/ptdt_slot_ram.sv]
// Slot table storage: one write port, one read port with registered data.
// Depends on ptdt_pkg for the slot record type.

module ptdt_slot_ram
    import ptdt_pkg::*;
#(
    parameter int DEPTH = SLOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output slot_t         rdata
);

    slot_t mem [0:DEPTH-1];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/periodic_task_dispatch_table_core.sv]
// Periodic task dispatch table, top level: transaction sequencer around the slot RAM.
// Depends on ptdt_pkg and ptdt_slot_ram.
//
// Usage:
//   Input stream (s_axis_*): one transaction per request. tuser carries the action
//   (add, remove, tick); tdata carries task id, period, kind and priority.
//   Output stream (m_axis_*): an add, remove or unused action returns exactly one
//   transaction with tlast high. A tick returns one transaction per due task, at most
//   RESULT_CAP, in table order (tuser high, task id in tdata), tlast on the final one;
//   a tick with nothing due returns one transaction with tuser low and tlast high.
//   Timing: the sequencer walks the slot RAM one entry per cycle through its single
//   read port, except while a tick holds for the output register. Add walks down to
//   the insert point, remove and tick walk every occupied slot; an empty table or a
//   rejected add skips the walk. s_axis_tready is high only while the sequencer is idle.
//   A finished result waits in the output register while the next request is
//   accepted. If the receiver stalls during a tick, the scan holds on the next due
//   task until the output register frees up; nothing is dropped.
//   Reset clears the time counter and the slot count; no RAM clearing is needed.

module periodic_task_dispatch_table_core
    import ptdt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // task_id[7:0], period_ms[23:8], kind[25:24],
                                        // priority_req[33:26], zero pad
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[2:0], fired_task[10:3], zero pad
    output logic        m_axis_tuser,   // fired
    output logic        m_axis_tlast
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(RESULT_CAP + 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [31:0]      now_reg, now_next;
    action_t          act_reg, act_next;
    slot_t            new_reg, new_next;
    status_t          status_reg, status_next;
    logic [CW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    wr_reg, wr_next;
    logic             found_reg, found_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [7:0]       hold_task_reg, hold_task_next;

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic             out_fired_reg;
    logic [7:0]       out_task_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             out_load;
    status_t          out_status_in;
    logic             out_fired_in;
    logic [7:0]       out_task_in;
    logic             out_last_in;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    slot_t            mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    slot_t            mem_rdata;

    action_t          in_action;
    logic [7:0]       in_id;
    logic [15:0]      in_period;
    logic [1:0]       in_kind;
    logic [7:0]       in_prio;

    slot_t            upd_slot;
    logic             due;
    logic             at_end;
    logic [CW-1:0]    used_m1;

    assign in_action = action_t'(s_axis_tuser);
    assign in_id     = s_axis_tdata[7:0];
    assign in_period = s_axis_tdata[23:8];
    assign in_kind   = s_axis_tdata[25:24];
    assign in_prio   = s_axis_tdata[33:26];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign used_m1       = used_reg - CW'(1);
    assign at_end        = (rd_reg == used_m1);

    always_comb
    begin
        upd_slot          = mem_rdata;
        upd_slot.next_due = mem_rdata.next_due + {16'd0, mem_rdata.period};
    end

    assign due = (n_reg < NW'(RESULT_CAP)) && (mem_rdata.next_due == now_reg);

    ptdt_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            now_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            now_reg        <= now_next;
            hold_valid_reg <= hold_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        new_reg       <= new_next;
        status_reg    <= status_next;
        rd_reg        <= rd_next;
        wr_reg        <= wr_next;
        found_reg     <= found_next;
        n_reg         <= n_next;
        hold_task_reg <= hold_task_next;
        if (out_load)
        begin
            out_status_reg <= out_status_in;
            out_fired_reg  <= out_fired_in;
            out_task_reg   <= out_task_in;
            out_last_reg   <= out_last_in;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        now_next        = now_reg;
        act_next        = act_reg;
        new_next        = new_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        found_next      = found_reg;
        n_next          = n_reg;
        hold_valid_next = hold_valid_reg;
        hold_task_next  = hold_task_reg;

        out_load      = 1'b0;
        out_status_in = ST_OK;
        out_fired_in  = 1'b0;
        out_task_in   = 8'd0;
        out_last_in   = 1'b1;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next          = in_action;
                    new_next.task_id  = in_id;
                    new_next.prio     = in_prio;
                    new_next.period   = in_period;
                    new_next.periodic = in_kind[0];
                    new_next.next_due = now_reg + {16'd0, in_period};
                    status_next       = ST_OK;
                    rd_next           = '0;
                    wr_next           = '0;
                    found_next        = 1'b0;
                    n_next            = '0;
                    hold_valid_next   = 1'b0;
                    state_next        = S_DONE;
                    case (in_action)
                        ACT_ADD:
                        begin
                            if (used_reg == CW'(SLOTS))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (in_id == 8'd0)
                            begin
                                status_next = ST_NULL_TASK;
                            end
                            else if (in_kind != KIND_ONESHOT && in_kind != KIND_PERIODIC)
                            begin
                                status_next = ST_BAD_KIND;
                            end
                            else if (in_period == 16'd0)
                            begin
                                status_next = ST_ZERO_PERIOD;
                            end
                            else if (used_reg == '0)
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = '0;
                                mem_wdata.task_id  = in_id;
                                mem_wdata.prio     = in_prio;
                                mem_wdata.period   = in_period;
                                mem_wdata.periodic = in_kind[0];
                                mem_wdata.next_due = now_reg + {16'd0, in_period};
                                used_next          = CW'(1);
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = used_m1[AW-1:0];
                                rd_next    = used_m1;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (used_reg == '0)
                            begin
                                status_next = ST_NOTHING;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                            if (used_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(rd_reg + CW'(1));
                        if (mem_rdata.prio > new_reg.prio)
                        begin
                            mem_wdata = mem_rdata;
                            if (rd_reg == '0)
                            begin
                                state_next = S_INS;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(rd_reg - CW'(1));
                                rd_next   = rd_reg - CW'(1);
                            end
                        end
                        else
                        begin
                            mem_wdata  = new_reg;
                            used_next  = used_reg + CW'(1);
                            state_next = S_DONE;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!found_reg && mem_rdata.task_id == new_reg.task_id)
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = wr_reg[AW-1:0];
                            mem_wdata = mem_rdata;
                            wr_next   = wr_reg + CW'(1);
                        end
                        if (at_end)
                        begin
                            used_next  = wr_next;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(rd_reg + CW'(1));
                            rd_next   = rd_reg + CW'(1);
                        end
                    end
                    ACT_TICK:
                    begin
                        if (!(due && hold_valid_reg && !out_free))
                        begin
                            if (due)
                            begin
                                if (hold_valid_reg)
                                begin
                                    out_load     = 1'b1;
                                    out_fired_in = 1'b1;
                                    out_task_in  = hold_task_reg;
                                    out_last_in  = 1'b0;
                                end
                                hold_valid_next = 1'b1;
                                hold_task_next  = mem_rdata.task_id;
                                n_next          = n_reg + NW'(1);
                            end
                            if (!due || mem_rdata.periodic)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = wr_reg[AW-1:0];
                                mem_wdata = due ? upd_slot : mem_rdata;
                                wr_next   = wr_reg + CW'(1);
                            end
                            if (at_end)
                            begin
                                used_next  = wr_next;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(rd_reg + CW'(1));
                                rd_next   = rd_reg + CW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_INS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = new_reg;
                used_next  = used_reg + CW'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_in   = status_reg;
                    out_fired_in    = hold_valid_reg;
                    out_task_in     = hold_valid_reg ? hold_task_reg : 8'd0;
                    out_last_in     = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_task_reg, out_status_reg};
    assign m_axis_tuser  = out_fired_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(SLOTS))
        else $error("slot count exceeds table depth");

    a_result_cap : assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(RESULT_CAP) || state_reg == S_IDLE)
        else $error("tick reported more tasks than the result cap");

    a_tick_advance : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_TICK)
        |=> now_reg == $past(now_reg) + 32'd1)
        else $error("time counter did not advance on tick");

    a_mid_is_fired : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
        else $error("non-final result without a fired task");
`endif

endmodule
